/* hdl/e2d_pkg.sv */
// Shared widths, constants and calendar helpers for the epoch seconds to date converter.
package e2d_pkg;

   localparam int SECONDS_BITS  = 32;
   localparam int SEC_IN_W      = 32;
   localparam int YEAR_W        = 12;
   localparam int MONTH_W       = 4;
   localparam int DOM_W         = 5;
   localparam int HOUR_W        = 5;
   localparam int MINUTE_W      = 6;
   localparam int SECOND_W      = 6;

   localparam int NUM_STAGES    = 16;

   localparam int MIN_SECS      = 60;
   localparam int HOUR_MINS     = 60;
   localparam int DAY_HOURS     = 24;
   localparam int YEAR_DAYS     = 365;
   localparam int QUAD_DAYS     = 1460;
   localparam int CENTURY_DAYS  = 36524;
   localparam int CYCLE_DAYS    = 146097;
   localparam int CYCLE_YEARS   = 400;
   localparam int MARCH_OFFSET  = 60;
   localparam int Z_OFFSET      = CYCLE_DAYS - MARCH_OFFSET;
   localparam int EPOCH_RESET   = 1970;

   localparam int Q60A_W        = SECONDS_BITS - 5;
   localparam int Q60B_W        = Q60A_W - 5;
   localparam int DAYS_W        = Q60B_W - 4;
   localparam int R60_W         = 7;
   localparam int R24_W         = 6;

   localparam longint unsigned RECIP_60A = (64'd1 << SECONDS_BITS) / MIN_SECS;
   localparam longint unsigned RECIP_60B = (64'd1 << Q60A_W) / HOUR_MINS;
   localparam longint unsigned RECIP_24  = (64'd1 << Q60B_W) / DAY_HOURS;

   localparam int BASE_W        = 21;
   localparam int ABS_W         = ((DAYS_W > BASE_W) ? DAYS_W : BASE_W) + 1;
   localparam int ERA_W         = ABS_W - 17;
   localparam longint unsigned RECIP_ERA = (64'd1 << ABS_W) / CYCLE_DAYS;

   localparam int DOE_W         = 18;
   localparam int Q1460_W       = DOE_W - 10;
   localparam int R365_W        = DOE_W - 8;
   localparam int QC_W          = 3;
   localparam int YOE_W         = 9;
   localparam int DOY_W         = 9;
   localparam int MP_W          = 4;
   localparam int C100_W        = 2;
   localparam longint unsigned RECIP_1460 = (64'd1 << DOE_W) / QUAD_DAYS;
   localparam longint unsigned RECIP_365  = (64'd1 << DOE_W) / YEAR_DAYS;

   localparam int YP_W          = YEAR_W + 1;
   localparam int CENT_W        = 6;
   localparam int DIV100_RECIP  = 5243;
   localparam int DIV100_W      = 13;
   localparam int DIV100_SHIFT  = 19;

   // first day of each month counted from March 1
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

/* hdl/e2d_epoch_base.sv */
// Epoch year register and the day number of its January 1 counted from year zero.
module e2d_epoch_base
   import e2d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [YEAR_W-1:0] csr_epoch_year,
   output logic [BASE_W-1:0] base_days
);

   localparam int PROD_W = YP_W + DIV100_W;

   logic [YEAR_W-1:0] epoch_ff;
   logic [YEAR_W-1:0] epoch_in;
   logic [YEAR_W-1:0] yr_ff;
   logic [CENT_W-1:0] cent_lo_ff;
   logic [CENT_W-1:0] cent_lo_in;
   logic [CENT_W-1:0] cent_hi_ff;
   logic [CENT_W-1:0] cent_hi_in;
   logic [BASE_W-1:0] base_ff;
   logic [BASE_W-1:0] base_in;
   logic [YP_W-1:0]   lo_x;
   logic [YP_W-1:0]   hi_x;
   logic [YP_W-1:0]   quad_x;
   logic [PROD_W-1:0] lo_prod;
   logic [PROD_W-1:0] hi_prod;

   assign csr_ready = 1'b1;
   assign epoch_in  = (csr_valid && csr_ready) ? csr_epoch_year : epoch_ff;

   always_comb begin
      lo_x       = YP_W'(epoch_ff) + YP_W'(99);
      hi_x       = YP_W'(epoch_ff) + YP_W'(399);
      lo_prod    = PROD_W'(lo_x) * PROD_W'(DIV100_RECIP);
      hi_prod    = PROD_W'(hi_x) * PROD_W'(DIV100_RECIP);
      cent_lo_in = lo_prod[DIV100_SHIFT +: CENT_W];
      cent_hi_in = hi_prod[DIV100_SHIFT +: CENT_W];
      quad_x     = YP_W'(yr_ff) + YP_W'(3);
      base_in    = BASE_W'(yr_ff) * BASE_W'(YEAR_DAYS) + BASE_W'(quad_x >> 2)
                   - BASE_W'(cent_lo_ff) + BASE_W'(cent_hi_ff >> 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= YEAR_W'(EPOCH_RESET);
      end else begin
         epoch_ff <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      yr_ff      <= epoch_ff;
      cent_lo_ff <= cent_lo_in;
      cent_hi_ff <= cent_hi_in;
      base_ff    <= base_in;
   end

   assign base_days = base_ff;

endmodule

/* hdl/epoch_seconds_to_date.sv */
// Top level: pipelined conversion of epoch seconds to calendar date and time of day.
//
// req_ channel carries a seconds count; a transaction is taken when req_valid is
// high and req_stall is low. rsp_ channel returns year, month, day, hour, minute
// and second; a transaction completes when rsp_valid is high and rsp_stall low.
// csr_ channel writes the epoch year (reset value 1970); csr_ready is always high.
// Write it only while no transaction is in flight.
// From request to result a transaction passes six stages for the time of day
// (three reciprocal multiply and correct steps), one for the day number, six for
// era and year of era (three more such steps), then day of year, month and the
// output register. Throughput is one transaction per cycle without output stalls.
// While rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is raised; nothing is dropped or repeated.
// Reset clears all valid bits and loads the epoch year; the derived day
// offset settles in u_base well before any request reaches the stage using it.
module epoch_seconds_to_date
   import e2d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SEC_IN_W-1:0] req_seconds_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [YEAR_W-1:0]   rsp_year_out,
   output logic [MONTH_W-1:0]  rsp_month_out,
   output logic [DOM_W-1:0]    rsp_day_out,
   output logic [HOUR_W-1:0]   rsp_hour_out,
   output logic [MINUTE_W-1:0] rsp_minute_out,
   output logic [SECOND_W-1:0] rsp_second_out,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [YEAR_W-1:0]   csr_epoch_year
);

   localparam int P1_W  = SECONDS_BITS + Q60A_W;
   localparam int P3_W  = Q60A_W + Q60B_W;
   localparam int P5_W  = Q60B_W + DAYS_W;
   localparam int P8_W  = ABS_W + ERA_W;
   localparam int P10_W = DOE_W + Q1460_W;
   localparam int P12_W = DOE_W + R365_W;

   logic                    adv;
   logic [NUM_STAGES:1]     vld_ff;
   logic [NUM_STAGES:1]     vld_in;
   logic [BASE_W-1:0]       base_days;

   logic [SECOND_W-1:0]     sec_ff  [2:NUM_STAGES];
   logic [MINUTE_W-1:0]     min_ff  [4:NUM_STAGES];
   logic [HOUR_W-1:0]       hour_ff [6:NUM_STAGES];
   logic [SECOND_W-1:0]     sec_in;
   logic [MINUTE_W-1:0]     min_in;
   logic [HOUR_W-1:0]       hour_in;

   logic [SECONDS_BITS-1:0] s1_t_ff, s1_t_in;
   logic [Q60A_W-1:0]       s1_q_ff, s1_q_in;
   logic [P1_W-1:0]         s1_prod;
   logic [SECONDS_BITS-1:0] s2_rem;
   logic [Q60A_W-1:0]       s2_q_ff, s2_q_in;
   logic [Q60B_W-1:0]       s3_q_ff, s3_q_in;
   logic [Q60A_W-1:0]       s3_x_ff;
   logic [P3_W-1:0]         s3_prod;
   logic [Q60A_W-1:0]       s4_rem;
   logic [Q60B_W-1:0]       s4_q_ff, s4_q_in;
   logic [Q60B_W-1:0]       s5_x_ff;
   logic [DAYS_W-1:0]       s5_q_ff, s5_q_in;
   logic [P5_W-1:0]         s5_prod;
   logic [Q60B_W-1:0]       s6_rem;
   logic [DAYS_W-1:0]       s6_days_ff, s6_days_in;
   logic [ABS_W-1:0]        s7_z_ff, s7_z_in;
   logic [ABS_W-1:0]        s8_z_ff;
   logic [ERA_W-1:0]        s8_q_ff, s8_q_in;
   logic [P8_W-1:0]         s8_prod;
   logic [ABS_W-1:0]        s9_rem;
   logic [DOE_W-1:0]        s9_doe_ff, s9_doe_in;
   logic [ERA_W-1:0]        s9_era_ff, s9_era_in;
   logic [P10_W-1:0]        s10_prod;
   logic [DOE_W-1:0]        s10_doe_ff;
   logic [ERA_W-1:0]        s10_era_ff;
   logic [Q1460_W-1:0]      s10_q_ff, s10_q_in;
   logic [QC_W-1:0]         s10_qc_ff, s10_qc_in;
   logic                    s10_last_ff, s10_last_in;
   logic [DOE_W-1:0]        s11_rem;
   logic [Q1460_W-1:0]      s11_q;
   logic [DOE_W-1:0]        s11_n_ff, s11_n_in;
   logic [DOE_W-1:0]        s11_doe_ff;
   logic [ERA_W-1:0]        s11_era_ff;
   logic [P12_W-1:0]        s12_prod;
   logic [DOE_W-1:0]        s12_n_ff;
   logic [YOE_W-1:0]        s12_q_ff, s12_q_in;
   logic [DOE_W-1:0]        s12_doe_ff;
   logic [ERA_W-1:0]        s12_era_ff;
   logic [DOE_W-1:0]        s13_rem;
   logic [YOE_W-1:0]        s13_yoe_ff, s13_yoe_in;
   logic [DOE_W-1:0]        s13_doe_ff;
   logic [ERA_W-1:0]        s13_era_ff;
   logic [C100_W-1:0]       s14_c100;
   logic [DOE_W-1:0]        s14_yday;
   logic [DOY_W-1:0]        s14_doy_ff, s14_doy_in;
   logic [YEAR_W-1:0]       s14_ybase_ff, s14_ybase_in;
   logic [MP_W-1:0]         s15_mp_ff, s15_mp_in;
   logic [DOY_W-1:0]        s15_doy_ff;
   logic [YEAR_W-1:0]       s15_ybase_ff;
   logic [YEAR_W-1:0]       year_ff, year_in;
   logic [MONTH_W-1:0]      month_ff, month_in;
   logic [DOM_W-1:0]        day_ff, day_in;

   e2d_epoch_base u_base (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_epoch_year (csr_epoch_year),
      .base_days      (base_days)
   );

   assign adv       = !(vld_ff[NUM_STAGES] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[NUM_STAGES-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // time of day: divide by 60, 60, 24
   always_comb begin
      s1_t_in = SECONDS_BITS'(req_seconds_count);
      s1_prod = P1_W'(s1_t_in) * P1_W'(RECIP_60A);
      s1_q_in = s1_prod[SECONDS_BITS +: Q60A_W];

      s2_rem = s1_t_ff - SECONDS_BITS'(s1_q_ff) * SECONDS_BITS'(MIN_SECS);
      if (s2_rem[R60_W-1:0] >= R60_W'(MIN_SECS)) begin
         s2_q_in = s1_q_ff + Q60A_W'(1);
         sec_in  = SECOND_W'(s2_rem[R60_W-1:0] - R60_W'(MIN_SECS));
      end else begin
         s2_q_in = s1_q_ff;
         sec_in  = SECOND_W'(s2_rem[R60_W-1:0]);
      end

      s3_prod = P3_W'(s2_q_ff) * P3_W'(RECIP_60B);
      s3_q_in = s3_prod[Q60A_W +: Q60B_W];

      s4_rem = s3_x_ff - Q60A_W'(s3_q_ff) * Q60A_W'(HOUR_MINS);
      if (s4_rem[R60_W-1:0] >= R60_W'(HOUR_MINS)) begin
         s4_q_in = s3_q_ff + Q60B_W'(1);
         min_in  = MINUTE_W'(s4_rem[R60_W-1:0] - R60_W'(HOUR_MINS));
      end else begin
         s4_q_in = s3_q_ff;
         min_in  = MINUTE_W'(s4_rem[R60_W-1:0]);
      end

      s5_prod = P5_W'(s4_q_ff) * P5_W'(RECIP_24);
      s5_q_in = s5_prod[Q60B_W +: DAYS_W];

      s6_rem = s5_x_ff - Q60B_W'(s5_q_ff) * Q60B_W'(DAY_HOURS);
      if (s6_rem[R24_W-1:0] >= R24_W'(DAY_HOURS)) begin
         s6_days_in = s5_q_ff + DAYS_W'(1);
         hour_in    = HOUR_W'(s6_rem[R24_W-1:0] - R24_W'(DAY_HOURS));
      end else begin
         s6_days_in = s5_q_ff;
         hour_in    = HOUR_W'(s6_rem[R24_W-1:0]);
      end
   end

   // day number, 400-year era and day of era
   always_comb begin
      s7_z_in = ABS_W'(base_days) + ABS_W'(s6_days_ff) + ABS_W'(Z_OFFSET);

      s8_prod = P8_W'(s7_z_ff) * P8_W'(RECIP_ERA);
      s8_q_in = s8_prod[ABS_W +: ERA_W];

      s9_rem = s8_z_ff - ABS_W'(s8_q_ff) * ABS_W'(CYCLE_DAYS);
      if (s9_rem >= ABS_W'(CYCLE_DAYS)) begin
         s9_doe_in = DOE_W'(s9_rem - ABS_W'(CYCLE_DAYS));
         s9_era_in = s8_q_ff + ERA_W'(1);
      end else begin
         s9_doe_in = DOE_W'(s9_rem);
         s9_era_in = s8_q_ff;
      end
   end

   // year of era
   always_comb begin
      s10_prod = P10_W'(s9_doe_ff) * P10_W'(RECIP_1460);
      s10_q_in = s10_prod[DOE_W +: Q1460_W];
      s10_qc_in = '0;
      for (int k = 1; k <= 4; k++) begin
         if (s9_doe_ff >= DOE_W'(k * CENTURY_DAYS)) begin
            s10_qc_in = s10_qc_in + QC_W'(1);
         end
      end
      s10_last_in = (s9_doe_ff == DOE_W'(CYCLE_DAYS - 1));

      s11_rem = s10_doe_ff - DOE_W'(s10_q_ff) * DOE_W'(QUAD_DAYS);
      s11_q   = (s11_rem >= DOE_W'(QUAD_DAYS)) ? s10_q_ff + Q1460_W'(1) : s10_q_ff;
      s11_n_in = s10_doe_ff - DOE_W'(s11_q) + DOE_W'(s10_qc_ff) - DOE_W'(s10_last_ff);

      s12_prod = P12_W'(s11_n_ff) * P12_W'(RECIP_365);
      s12_q_in = s12_prod[DOE_W +: YOE_W];

      s13_rem    = s12_n_ff - DOE_W'(s12_q_ff) * DOE_W'(YEAR_DAYS);
      s13_yoe_in = (s13_rem >= DOE_W'(YEAR_DAYS)) ? s12_q_ff + YOE_W'(1) : s12_q_ff;
   end

   // day of year, month and final fields
   always_comb begin
      s14_c100 = '0;
      for (int k = 1; k <= 3; k++) begin
         if (s13_yoe_ff >= YOE_W'(k * 100)) begin
            s14_c100 = s14_c100 + C100_W'(1);
         end
      end
      s14_yday = s13_doe_ff - (DOE_W'(s13_yoe_ff) * DOE_W'(YEAR_DAYS)
                 + DOE_W'(s13_yoe_ff >> 2) - DOE_W'(s14_c100));
      s14_doy_in   = DOY_W'(s14_yday);
      s14_ybase_in = YEAR_W'(s13_era_ff) * YEAR_W'(CYCLE_YEARS) + YEAR_W'(s13_yoe_ff)
                     - YEAR_W'(CYCLE_YEARS);

      s15_mp_in = '0;
      for (int k = 1; k <= 11; k++) begin
         if (s14_doy_ff >= month_start(MP_W'(k))) begin
            s15_mp_in = s15_mp_in + MP_W'(1);
         end
      end

      day_in = DOM_W'(s15_doy_ff - month_start(s15_mp_ff) + DOY_W'(1));
      if (s15_mp_ff >= MP_W'(10)) begin
         month_in = MONTH_W'(s15_mp_ff - MP_W'(9));
         year_in  = s15_ybase_ff + YEAR_W'(1);
      end else begin
         month_in = MONTH_W'(s15_mp_ff + MP_W'(3));
         year_in  = s15_ybase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_t_ff      <= s1_t_in;
         s1_q_ff      <= s1_q_in;
         s2_q_ff      <= s2_q_in;
         s3_x_ff      <= s2_q_ff;
         s3_q_ff      <= s3_q_in;
         s4_q_ff      <= s4_q_in;
         s5_x_ff      <= s4_q_ff;
         s5_q_ff      <= s5_q_in;
         s6_days_ff   <= s6_days_in;
         s7_z_ff      <= s7_z_in;
         s8_z_ff      <= s7_z_ff;
         s8_q_ff      <= s8_q_in;
         s9_doe_ff    <= s9_doe_in;
         s9_era_ff    <= s9_era_in;
         s10_doe_ff   <= s9_doe_ff;
         s10_era_ff   <= s9_era_ff;
         s10_q_ff     <= s10_q_in;
         s10_qc_ff    <= s10_qc_in;
         s10_last_ff  <= s10_last_in;
         s11_n_ff     <= s11_n_in;
         s11_doe_ff   <= s10_doe_ff;
         s11_era_ff   <= s10_era_ff;
         s12_n_ff     <= s11_n_ff;
         s12_q_ff     <= s12_q_in;
         s12_doe_ff   <= s11_doe_ff;
         s12_era_ff   <= s11_era_ff;
         s13_yoe_ff   <= s13_yoe_in;
         s13_doe_ff   <= s12_doe_ff;
         s13_era_ff   <= s12_era_ff;
         s14_doy_ff   <= s14_doy_in;
         s14_ybase_ff <= s14_ybase_in;
         s15_mp_ff    <= s15_mp_in;
         s15_doy_ff   <= s14_doy_ff;
         s15_ybase_ff <= s14_ybase_ff;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;

         sec_ff[2] <= sec_in;
         for (int i = 3; i <= NUM_STAGES; i++) begin
            sec_ff[i] <= sec_ff[i-1];
         end
         min_ff[4] <= min_in;
         for (int i = 5; i <= NUM_STAGES; i++) begin
            min_ff[i] <= min_ff[i-1];
         end
         hour_ff[6] <= hour_in;
         for (int i = 7; i <= NUM_STAGES; i++) begin
            hour_ff[i] <= hour_ff[i-1];
         end
      end
   end

   assign rsp_valid      = vld_ff[NUM_STAGES];
   assign rsp_year_out   = year_ff;
   assign rsp_month_out  = month_ff;
   assign rsp_day_out    = day_ff;
   assign rsp_hour_out   = hour_ff[NUM_STAGES];
   assign rsp_minute_out = min_ff[NUM_STAGES];
   assign rsp_second_out = sec_ff[NUM_STAGES];

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline valid bits not cleared by reset");

   a_doe_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[9] |-> (s9_doe_ff < DOE_W'(CYCLE_DAYS)))
      else $error("day of era out of range after correction");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour_out < HOUR_W'(DAY_HOURS)) &&
                    (rsp_minute_out < MINUTE_W'(HOUR_MINS)) &&
                    (rsp_second_out < SECOND_W'(MIN_SECS)))
      else $error("time of day field out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_out >= MONTH_W'(1)) && (rsp_month_out <= MONTH_W'(12)) &&
                    (rsp_day_out >= DOM_W'(1)) && (rsp_day_out <= DOM_W'(31)))
      else $error("month or day field out of range");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the epoch seconds to calendar date converter.
module tb_top
   import e2d_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH  = NUM_STAGES;
   localparam int PIPE_SETTLE = NUM_STAGES + 4;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DAY_SECS    = MIN_SECS * HOUR_MINS * DAY_HOURS;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DOM_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } date_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SEC_IN_W-1:0] req_seconds_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [YEAR_W-1:0]   rsp_year_out;
   logic [MONTH_W-1:0]  rsp_month_out;
   logic [DOM_W-1:0]    rsp_day_out;
   logic [HOUR_W-1:0]   rsp_hour_out;
   logic [MINUTE_W-1:0] rsp_minute_out;
   logic [SECOND_W-1:0] rsp_second_out;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [YEAR_W-1:0]   csr_epoch_year = '0;

   logic [YEAR_W-1:0]   epoch_now = YEAR_W'(EPOCH_RESET);
   date_type            dates_due[$];
   date_type            due_date;
   int                  mismatches = 0;
   int                  cycles = 0;
   int                  stall_left = 0;
   bit                  stall_on = 1'b1;
   bit                  gaps_on = 1'b1;
   bit                  long_hold_pending = 1'b0;

   epoch_seconds_to_date u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_seconds_count (req_seconds_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_year_out      (rsp_year_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_day_out       (rsp_day_out),
      .rsp_hour_out      (rsp_hour_out),
      .rsp_minute_out    (rsp_minute_out),
      .rsp_second_out    (rsp_second_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_epoch_year    (csr_epoch_year)
   );

   always #5 clock = ~clock;

   function automatic bit leap_year(input longint unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic longint unsigned month_days(input int unsigned m,
                                                  input longint unsigned y);
      case (m)
         1: begin
            return leap_year(y) ? 29 : 28;
         end
         3, 5, 8, 10: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic date_type to_calendar(input logic [YEAR_W-1:0] epoch,
                                            input logic [SEC_IN_W-1:0] secs);
      longint unsigned t;
      longint unsigned days;
      longint unsigned yr;
      longint unsigned ylen;
      int unsigned     mon;
      date_type        d;
      t = secs;
      if (SECONDS_BITS < 64) begin
         t = t & ((64'd1 << SECONDS_BITS) - 1);
      end
      d.second = SECOND_W'(t % MIN_SECS);
      t = t / MIN_SECS;
      d.minute = MINUTE_W'(t % HOUR_MINS);
      t = t / HOUR_MINS;
      d.hour = HOUR_W'(t % DAY_HOURS);
      days = t / DAY_HOURS;
      yr = epoch;
      ylen = leap_year(yr) ? 366 : 365;
      while (days >= ylen) begin
         days = days - ylen;
         yr++;
         ylen = leap_year(yr) ? 366 : 365;
      end
      mon = 0;
      while (mon < 11 && days >= month_days(mon, yr)) begin
         days = days - month_days(mon, yr);
         mon++;
      end
      d.year = YEAR_W'(yr);
      d.month = MONTH_W'(mon + 1);
      d.day = DOM_W'(days + 1);
      return d;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(10, 40);
      end
   endfunction

   function automatic logic [SEC_IN_W-1:0] rand_seconds();
      longint unsigned v;
      int              r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = $urandom;
      end else if (r < 82) begin
         v = longint'($urandom_range(0, 49710)) * DAY_SECS - 1 + $urandom_range(0, 2);
      end else begin
         v = $urandom_range(0, DAY_SECS * 1200);
      end
      return SEC_IN_W'(v);
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         dates_due.push_back(to_calendar(epoch_now, req_seconds_count));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dates_due.size() == 0) begin
            $error("result transaction with nothing outstanding");
            mismatches++;
         end else begin
            due_date = dates_due.pop_front();
            check_field("year_out", due_date.year, rsp_year_out);
            check_field("month_out", due_date.month, rsp_month_out);
            check_field("day_out", due_date.day, rsp_day_out);
            check_field("hour_out", due_date.hour, rsp_hour_out);
            check_field("minute_out", due_date.minute, rsp_minute_out);
            check_field("second_out", due_date.second, rsp_second_out);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         rsp_stall <= 1'b1;
         stall_left = LONG_HOLD - 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("epoch_seconds_to_date test failed");
         $finish;
      end
   end

   task automatic send_seconds(input logic [SEC_IN_W-1:0] secs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_seconds_count <= secs;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (dates_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_epoch(input logic [YEAR_W-1:0] yr);
      wait_drained();
      repeat (PIPE_DEPTH) @(posedge clock);
      csr_valid <= 1'b1;
      csr_epoch_year <= yr;
      do @(posedge clock); while (!csr_ready);
      epoch_now = yr;
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_epoch();
      logic [SEC_IN_W-1:0] picks[$];
      picks = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'd31535999, 32'd31536000, 32'd951782400, 32'd951868800,
                32'd946684799, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
      foreach (picks[i]) send_seconds(picks[i]);
   endtask

   task automatic test_epoch_extremes();
      set_epoch(YEAR_W'(1601));
      send_seconds(32'd0);
      send_seconds(32'hFFFF_FFFF);
      set_epoch(YEAR_W'(2399));
      send_seconds(32'd0);
      send_seconds(32'hFFFF_FFFF);
      set_epoch(YEAR_W'(0));
      send_seconds(32'd0);
      send_seconds(32'd59 * DAY_SECS);
      send_seconds(32'hFFFF_FFFF);
      set_epoch(YEAR_W'(4095));
      send_seconds(32'd0);
      send_seconds(32'd366 * DAY_SECS);
      send_seconds(32'hFFFF_FFFF);
      set_epoch(YEAR_W'(1900));
      send_seconds(32'd59 * DAY_SECS - 1);
      send_seconds(32'd59 * DAY_SECS);
   endtask

   task automatic test_random_epochs();
      logic [YEAR_W-1:0] epochs[5];
      epochs[0] = YEAR_W'(2000);
      epochs[1] = YEAR_W'($urandom_range(1601, 2399));
      epochs[2] = YEAR_W'($urandom_range(1601, 2399));
      epochs[3] = YEAR_W'($urandom_range(0, 4095));
      epochs[4] = YEAR_W'(EPOCH_RESET);
      foreach (epochs[e]) begin
         set_epoch(epochs[e]);
         repeat (330) send_seconds(rand_seconds());
      end
   endtask

   task automatic test_full_rate();
      wait_drained();
      stall_on = 1'b0;
      gaps_on = 1'b0;
      repeat (100) send_seconds(rand_seconds());
      stall_on = 1'b1;
      gaps_on = 1'b1;
   endtask

   task automatic test_long_backpressure();
      wait_drained();
      gaps_on = 1'b0;
      long_hold_pending = 1'b1;
      repeat (80) send_seconds(rand_seconds());
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_epoch();
      test_epoch_extremes();
      test_random_epochs();
      test_full_rate();
      test_long_backpressure();
      wait_drained();
      repeat (PIPE_SETTLE) @(posedge clock);
      if (dates_due.size() != 0) begin
         $error("%0d results never arrived", dates_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("epoch_seconds_to_date test passed");
      end else begin
         $display("epoch_seconds_to_date test failed");
      end
      $finish;
   end

endmodule
